FILE: rtl/core/mmc3mc_pkg.sv
// Shared types and constants of the MMC3 multicart bank mapper.
// No dependencies; the front, queue, remainder, back and top files import this package.
package mmc3mc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_TOTAL   = 2'd0;
  localparam logic [1:0] CFG_CHR_TOTAL   = 2'd1;
  localparam logic [1:0] CFG_QUAD_SCREEN = 2'd2;

  // Input modes
  localparam logic [2:0] MODE_MAPPER_WR = 3'd0;
  localparam logic [2:0] MODE_OUTER_WR  = 3'd1;
  localparam logic [2:0] MODE_TICK      = 3'd2;
  localparam logic [2:0] MODE_PRG       = 3'd3;
  localparam logic [2:0] MODE_CHR       = 3'd4;

  // Mapper register decode
  localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_SELECT       = 16'h8000;
  localparam logic [15:0] REG_BANK         = 16'h8001;
  localparam logic [15:0] REG_MIRROR       = 16'hA000;
  localparam logic [15:0] REG_LATCH        = 16'hC000;
  localparam logic [15:0] REG_RELOAD       = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF      = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON       = 16'hE001;
  localparam logic [15:0] PRG_WINDOW_BASE  = 16'h8000;
  localparam logic [15:0] CHR_WINDOW_END   = 16'h2000;

  localparam logic [1:0] MIRROR_QUAD_SCREEN = 2'd2;

  localparam int BANK_REG_COUNT = 8;
  localparam int BANK_IDX_W     = $clog2(BANK_REG_COUNT);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Remainder unit: two quotient bits per cycle over an 8-bit dividend
  localparam int REM_W      = 8;
  localparam int REM_STEPS  = 2;
  localparam int REM_CYCLES = REM_W / REM_STEPS;
  localparam int REM_CNT_W  = $clog2(REM_CYCLES);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SELECT,
    OP_BANK,
    OP_MIRROR,
    OP_LATCH,
    OP_RELOAD,
    OP_IRQ_OFF,
    OP_IRQ_ON,
    OP_OUTER,
    OP_TICK,
    OP_PRG,
    OP_CHR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] slot;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] prg_total;
    logic [7:0] chr_total;
    logic       quad_screen;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } rem_rsp_t;

endpackage

FILE: rtl/core/mmc3mc_ifs.sv
// Handshake channel interfaces of the MMC3 multicart bank mapper.
// No dependencies: input item, result item and configuration write channels.
interface mmc3mc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        show_background;
  logic        show_sprites;

  modport source (output valid, mode, bus_address, write_data, show_background,
                  show_sprites, input ready);
  modport sink (input valid, mode, bus_address, write_data, show_background,
                show_sprites, output ready);
endinterface

interface mmc3mc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mapped_bank;
  logic       irq_line;
  logic [1:0] mirroring_mode;

  modport source (output valid, mapped_bank, irq_line, mirroring_mode, input ready);
  modport sink (input valid, mapped_bank, irq_line, mirroring_mode, output ready);
endinterface

interface mmc3mc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/mmc3mc_front.sv
// Front end: accepts input transactions and decodes them into queue commands.
// Depends on mmc3mc_pkg and mmc3mc_in_if.
module mmc3mc_front (
  mmc3mc_in_if.sink      in_i,
  input  logic           q_ready_i,
  output logic           q_valid_o,
  output mmc3mc_pkg::cmd_t q_cmd_o
);
  import mmc3mc_pkg::*;

  logic [15:0] reg_addr;

  assign reg_addr  = in_i.bus_address & ADDR_DECODE_MASK;
  assign in_i.ready = q_ready_i;
  assign q_valid_o  = in_i.valid;

  // Classify the transaction; lookups outside their window and ticks with rendering off become no-ops
  always_comb begin
    q_cmd_o.op   = OP_NOP;
    q_cmd_o.slot = 3'd0;
    q_cmd_o.data = in_i.write_data;
    unique case (in_i.mode)
      MODE_MAPPER_WR: begin
        unique case (reg_addr)
          REG_SELECT:  q_cmd_o.op = OP_SELECT;
          REG_BANK:    q_cmd_o.op = OP_BANK;
          REG_MIRROR:  q_cmd_o.op = OP_MIRROR;
          REG_LATCH:   q_cmd_o.op = OP_LATCH;
          REG_RELOAD:  q_cmd_o.op = OP_RELOAD;
          REG_IRQ_OFF: q_cmd_o.op = OP_IRQ_OFF;
          REG_IRQ_ON:  q_cmd_o.op = OP_IRQ_ON;
          default:     q_cmd_o.op = OP_NOP;
        endcase
      end
      MODE_OUTER_WR: q_cmd_o.op = OP_OUTER;
      MODE_TICK: begin
        if (in_i.show_background || in_i.show_sprites) begin
          q_cmd_o.op = OP_TICK;
        end
      end
      MODE_PRG: begin
        if (in_i.bus_address >= PRG_WINDOW_BASE) begin
          q_cmd_o.op   = OP_PRG;
          q_cmd_o.slot = {1'b0, in_i.bus_address[14:13]};
        end
      end
      MODE_CHR: begin
        if (in_i.bus_address < CHR_WINDOW_END) begin
          q_cmd_o.op   = OP_CHR;
          q_cmd_o.slot = in_i.bus_address[12:10];
        end
      end
      default: q_cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: rtl/core/mmc3mc_queue.sv
// Short command queue decoupling the decode front from the execute back.
// Depends on mmc3mc_pkg.
module mmc3mc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  mmc3mc_pkg::cmd_t push_cmd_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output mmc3mc_pkg::cmd_t pop_cmd_o,
  input  logic             pop_i
);
  import mmc3mc_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/core/mmc3mc_rem.sv
// Iterative remainder unit, restoring scheme, two dividend bits per cycle.
// Depends on mmc3mc_pkg. Divisor must be non-zero.
module mmc3mc_rem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmc3mc_pkg::rem_req_t req_i,
  output mmc3mc_pkg::rem_rsp_t rsp_o
);
  import mmc3mc_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [REM_CNT_W-1:0] cnt_q;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [REM_W-1:0]     dvd_q, dvd_d;
  logic [REM_W-1:0]     dsr_q;

  // Two shift-compare-subtract steps
  always_comb begin
    logic [REM_W:0] trial;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int i = 0; i < REM_STEPS; i++) begin
      trial = {rem_d, dvd_d[REM_W-1]};
      dvd_d = {dvd_d[REM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == REM_CNT_W'(REM_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/core/mmc3mc_back.sv
// Back end: holds mapper state, executes queued commands, drives the result.
// Depends on mmc3mc_pkg, mmc3mc_out_if and mmc3mc_rem.
module mmc3mc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mmc3mc_pkg::cfg_t cfg_i,
  input  logic             q_valid_i,
  input  mmc3mc_pkg::cmd_t q_cmd_i,
  output logic             q_pop_o,
  mmc3mc_out_if.source     out_o
);
  import mmc3mc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } state_e;

  state_e st_q, st_d;

  // Mapper state
  logic [7:0] sel_q, sel_d;
  logic [7:0] bank_q [BANK_REG_COUNT];
  logic       mirror_q, mirror_d;
  logic [7:0] latch_q, latch_d;
  logic [7:0] irq_cnt_q, irq_cnt_d;
  logic       reload_q, reload_d;
  logic       irq_en_q, irq_en_d;
  logic       irq_pend_q, irq_pend_d;
  logic [2:0] outer_q, outer_d;

  // Lookup in flight
  logic [7:0] base_q;
  logic [2:0] low_q;
  logic       chr_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] out_bank_q;
  logic       out_irq_q;
  logic [1:0] out_mirror_q;

  cmd_t                  cmd;
  logic                  pop, need_mod, load_out;
  logic [BANK_IDX_W-1:0] rd_idx, prg_idx, chr_idx;
  logic [2:0]            chr_s;
  logic [7:0]            bank_rd, chr_raw;
  logic [5:0]            prg_seg;
  logic [4:0]            chr_seg;
  logic [7:0]            prg_off, chr_off, prg_last, prg_slast;
  logic [7:0]            direct_bank, mod_bank, out_bank_d;
  rem_req_t              rem_req;
  rem_rsp_t              rem_rsp;

  assign cmd = q_cmd_i;
  assign pop = q_valid_i && (st_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign q_pop_o = pop;

  // Bank register read, one address per lookup
  assign prg_idx = (cmd.slot[1:0] == 2'd1) ? BANK_IDX_W'(7) : BANK_IDX_W'(6);
  assign chr_s   = cmd.slot ^ {sel_q[7], 2'b00};
  assign chr_idx = chr_s[2] ? BANK_IDX_W'(chr_s - 3'd2) : BANK_IDX_W'({2'b00, chr_s[1]});
  assign rd_idx  = (cmd.op == OP_CHR) ? chr_idx : prg_idx;
  assign bank_rd = bank_q[rd_idx];
  assign chr_raw = chr_s[2] ? bank_rd : {bank_rd[7:1], chr_s[0]};

  // Segment geometry
  assign prg_seg   = (cfg_i.prg_total[7:2] == '0) ? 6'd1 : cfg_i.prg_total[7:2];
  assign chr_seg   = (cfg_i.chr_total[7:3] == '0) ? 5'd1 : cfg_i.chr_total[7:3];
  assign prg_off   = {2'b00, outer_q[1:0], 4'b0000};
  assign chr_off   = {2'b00, outer_q, 3'b000};
  assign prg_last  = prg_off + {2'b00, prg_seg} - 8'd1;
  assign prg_slast = prg_off + {2'b00, prg_seg} - 8'd2;

  // Lookups that resolve without a remainder
  always_comb begin
    direct_bank = 8'd0;
    need_mod    = 1'b0;
    unique case (cmd.op)
      OP_PRG: begin
        if (outer_q[2]) begin
          direct_bank = cfg_i.prg_total - 8'd4 + {6'b0, cmd.slot[1:0]};
        end else if (cmd.slot[1:0] == 2'd3) begin
          direct_bank = prg_last;
        end else if ((cmd.slot[1:0] == 2'd2 && !sel_q[6]) ||
                     (cmd.slot[1:0] == 2'd0 && sel_q[6])) begin
          direct_bank = prg_slast;
        end else begin
          need_mod = 1'b1;
        end
      end
      OP_CHR: begin
        if (cfg_i.chr_total == '0) begin
          direct_bank = {5'b0, cmd.slot};
        end else begin
          need_mod = 1'b1;
        end
      end
      default: direct_bank = 8'd0;
    endcase
  end

  // Remainder request: bank value modulo segment size
  always_comb begin
    rem_req.start = pop && need_mod;
    if (cmd.op == OP_CHR) begin
      rem_req.dividend = {3'b000, chr_raw[7:3]};
      rem_req.divisor  = {3'b000, chr_seg};
    end else begin
      rem_req.dividend = bank_rd;
      rem_req.divisor  = {2'b00, prg_seg};
    end
  end

  mmc3mc_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign mod_bank = chr_q ? base_q + {rem_rsp.rem[4:0], low_q} : base_q + rem_rsp.rem;

  // Command execution
  always_comb begin
    sel_d      = sel_q;
    mirror_d   = mirror_q;
    latch_d    = latch_q;
    irq_cnt_d  = irq_cnt_q;
    reload_d   = reload_q;
    irq_en_d   = irq_en_q;
    irq_pend_d = irq_pend_q;
    outer_d    = outer_q;
    if (pop) begin
      unique case (cmd.op)
        OP_SELECT:  sel_d    = cmd.data;
        OP_MIRROR:  mirror_d = cmd.data[0];
        OP_LATCH:   latch_d  = cmd.data;
        OP_RELOAD:  reload_d = 1'b1;
        OP_IRQ_OFF: begin
          irq_en_d   = 1'b0;
          irq_pend_d = 1'b0;
        end
        OP_IRQ_ON:  irq_en_d = 1'b1;
        OP_OUTER:   outer_d  = cmd.data[2:0];
        OP_TICK: begin
          if (irq_cnt_q == '0 || reload_q) begin
            irq_cnt_d = latch_q;
          end else begin
            irq_cnt_d = irq_cnt_q - 8'd1;
          end
          if (irq_cnt_d == '0 && irq_en_q) begin
            irq_pend_d = 1'b1;
          end
          reload_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    st_d     = st_q;
    load_out = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (pop) begin
          if (need_mod) begin
            st_d = ST_WAIT;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (rem_rsp.done) begin
          st_d     = ST_IDLE;
          load_out = 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_bank_d = (st_q == ST_WAIT) ? mod_bank : direct_bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      sel_q       <= '0;
      mirror_q    <= 1'b0;
      latch_q     <= '0;
      irq_cnt_q   <= '0;
      reload_q    <= 1'b0;
      irq_en_q    <= 1'b0;
      irq_pend_q  <= 1'b0;
      outer_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < BANK_REG_COUNT; i++) begin
        bank_q[i] <= (i == BANK_REG_COUNT - 1) ? 8'd1 : 8'd0;
      end
    end else begin
      st_q       <= st_d;
      sel_q      <= sel_d;
      mirror_q   <= mirror_d;
      latch_q    <= latch_d;
      irq_cnt_q  <= irq_cnt_d;
      reload_q   <= reload_d;
      irq_en_q   <= irq_en_d;
      irq_pend_q <= irq_pend_d;
      outer_q    <= outer_d;
      if (pop && cmd.op == OP_BANK) begin
        bank_q[sel_q[BANK_IDX_W-1:0]] <= cmd.data;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rem_req.start) begin
      chr_q  <= (cmd.op == OP_CHR);
      base_q <= (cmd.op == OP_CHR) ? chr_off : prg_off;
      low_q  <= chr_raw[2:0];
    end
    if (load_out) begin
      out_bank_q   <= out_bank_d;
      out_irq_q    <= irq_pend_d;
      out_mirror_q <= cfg_i.quad_screen ? MIRROR_QUAD_SCREEN : {1'b0, mirror_d};
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mapped_bank    = out_bank_q;
  assign out_o.irq_line       = out_irq_q;
  assign out_o.mirroring_mode = out_mirror_q;

endmodule

FILE: rtl/core/mmc3_multicart_bank_mapper_top.sv
// MMC3 bank mapper with a 3-bit outer multicart register. Each accepted bus
// event (mapper write, outer write, scanline tick, PRG or CHR lookup) yields
// one result transaction with the mapped bank, the IRQ line and the mirroring
// mode as they stand after the event. Events enter a two-entry command queue;
// writes, ticks and lookups of fixed slots load their result as they leave the
// queue, while PRG lookups of the switchable slots with outer bit 2 clear and
// CHR lookups with CHR ROM first start the remainder unit, which resolves two
// bits of the bank value at a time, and then load its result. The result sits
// in an output register, so the queue keeps filling while a result waits to be
// taken. Configuration writes are always accepted and should be made while
// no events are in flight.
// Depends on mmc3mc_pkg, mmc3mc_ifs, mmc3mc_front, mmc3mc_queue, mmc3mc_back.
module mmc3_multicart_bank_mapper_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmc3mc_in_if.sink     in_i,
  mmc3mc_out_if.source  out_o,
  mmc3mc_cfg_if.sink    cfg_i
);
  import mmc3mc_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop;
  cmd_t push_cmd, pop_cmd;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_total   <= 8'd16;
      cfg_q.chr_total   <= 8'd128;
      cfg_q.quad_screen <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PRG_TOTAL:   cfg_q.prg_total   <= cfg_i.data;
        CFG_CHR_TOTAL:   cfg_q.chr_total   <= cfg_i.data;
        CFG_QUAD_SCREEN: cfg_q.quad_screen <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  mmc3mc_front u_front (
    .in_i      (in_i),
    .q_ready_i (push_ready),
    .q_valid_o (push_valid),
    .q_cmd_o   (push_cmd)
  );

  mmc3mc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  mmc3mc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

FILE: rtl/core/mmc3mc_checker.sv
// Port-level checker of the MMC3 multicart bank mapper, bound to the top.
// Depends on mmc3_multicart_bank_mapper_top and its channel interfaces.
module mmc3mc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_bank_i,
  input logic       out_irq_i,
  input logic [1:0] out_mirror_i,
  input logic       cfg_ready_i
);

  logic [2:0] open_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      open_q <= open_q - 3'd1;
    end
  end

  // A result is never offered without an event behind it
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 3'd0)
    else $error("result offered with no outstanding transaction");

  // Queue plus execute stage plus output register bound the backlog
  a_backlog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'd4)
    else $error("more transactions in flight than the block can hold");

  // Four-screen is the highest mirroring code
  a_mirror_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_mirror_i != 2'd3)
    else $error("invalid mirroring code");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bank_i) &&
      $stable(out_irq_i) && $stable(out_mirror_i))
    else $error("stalled result changed");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind mmc3_multicart_bank_mapper_top mmc3mc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_bank_i   (out_o.mapped_bank),
  .out_irq_i    (out_o.irq_line),
  .out_mirror_i (out_o.mirroring_mode),
  .cfg_ready_i  (cfg_i.ready)
);
